/* rtl/core/wto_pkg.sv */
// Shared types and constants for the wavetable oscillator core.
package wto_pkg;

	localparam int PhaseW   = 32;
	localparam int AddrW    = 8;
	localparam int FracW    = 8;
	localparam int SampleW  = 8;
	localparam int ProdW    = SampleW + FracW + 1;
	localparam int TableDepth = 1 << AddrW;

	localparam logic [FracW-1:0] WeightFull = 8'd255;

	// Item function codes.
	localparam logic FuncTick  = 1'b0;
	localparam logic FuncWrite = 1'b1;

	// Table write request.
	typedef struct packed {
		logic                      en;
		logic [AddrW-1:0]          addr;
		logic signed [SampleW-1:0] data;
	} wr_req_t;

	// Control that travels with the registered table read.
	typedef struct packed {
		logic             valid;
		logic [FracW-1:0] frac;
	} rd_ctl_t;

endpackage

/* rtl/core/wto_if.sv */
// Valid/ready channel interfaces for the input and result items.
interface wto_in_if;
	logic                                         valid;
	logic                                         ready;
	logic                                         func;
	logic [wto_pkg::AddrW-1:0]                    entry_addr;
	logic signed [wto_pkg::SampleW-1:0]           entry_value;

	modport source (output valid, output func, output entry_addr, output entry_value,
		input ready);
	modport sink (input valid, input func, input entry_addr, input entry_value,
		output ready);
endinterface

interface wto_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [wto_pkg::SampleW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* rtl/core/wavetable_oscillator_interp_core.sv */
// Wavetable oscillator top level: phase accumulator, table and interpolation pipeline.
// A tick's sample passes the table read, product and output registers in turn.
// One item per cycle unless stalled; the phase add is the only loop-carried path.
// The whole pipeline stalls only while a finished sample waits on the output.
// Reset clears phase, phase_step and all valid flags; table contents stay undefined.
module wavetable_oscillator_interp_core (
	input  logic                              clk,
	input  logic                              arst_n,
	wto_in_if.sink                            in_ch,
	wto_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [wto_pkg::PhaseW-1:0]        cfg_data
);

	logic [wto_pkg::PhaseW-1:0]         phase_step_q;
	logic [wto_pkg::PhaseW-1:0]         phase_q;
	logic                               advance;
	logic                               accept;
	logic                               tick_acc;
	logic [wto_pkg::AddrW-1:0]          pos;
	logic [wto_pkg::AddrW-1:0]          nxt;
	wto_pkg::wr_req_t                   wr;
	wto_pkg::rd_ctl_t                   ctl_s1;
	logic signed [wto_pkg::SampleW-1:0] a_s1;
	logic signed [wto_pkg::SampleW-1:0] b_s1;
	logic                               out_valid;

	assign advance  = !out_valid || out_ch.ready;
	assign accept   = in_ch.valid && advance;
	assign tick_acc = accept && (in_ch.func == wto_pkg::FuncTick);

	assign in_ch.ready = advance;

	assign pos = phase_q[wto_pkg::PhaseW-1 -: wto_pkg::AddrW];
	assign nxt = pos + wto_pkg::AddrW'(1);

	// A write lands at its accept edge, so a tick in the next cycle already sees it.
	assign wr.en   = accept && (in_ch.func == wto_pkg::FuncWrite);
	assign wr.addr = in_ch.entry_addr;
	assign wr.data = in_ch.entry_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			phase_q      <= '0;
			ctl_s1       <= '0;
		end else begin
			if (cfg_we) begin
				phase_step_q <= cfg_data;
			end
			if (tick_acc) begin
				phase_q <= phase_q + phase_step_q;
			end
			if (advance) begin
				ctl_s1.valid <= tick_acc;
				ctl_s1.frac  <= phase_q[wto_pkg::PhaseW-wto_pkg::AddrW-1 -: wto_pkg::FracW];
			end
		end
	end

	wto_table u_table (
		.clk       (clk),
		.rd_en     (advance),
		.rd_addr_a (pos),
		.rd_addr_b (nxt),
		.wr        (wr),
		.rd_data_a (a_s1),
		.rd_data_b (b_s1)
	);

	wto_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.valid_q  (out_valid),
		.sample_q (out_ch.sample)
	);

	assign out_ch.valid = out_valid;

endmodule

/* rtl/core/wto_table.sv */
// Wave table memory: one write port and two registered read ports.
module wto_table (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [wto_pkg::AddrW-1:0]           rd_addr_a,
	input  logic [wto_pkg::AddrW-1:0]           rd_addr_b,
	input  wto_pkg::wr_req_t                    wr,
	output logic signed [wto_pkg::SampleW-1:0]  rd_data_a,
	output logic signed [wto_pkg::SampleW-1:0]  rd_data_b
);

	logic signed [wto_pkg::SampleW-1:0] mem [wto_pkg::TableDepth];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

/* rtl/core/wto_interp.sv */
// Interpolation pipeline: weight products, then sum and output register.
module wto_interp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  wto_pkg::rd_ctl_t                   ctl_s1,
	input  logic signed [wto_pkg::SampleW-1:0] a_s1,
	input  logic signed [wto_pkg::SampleW-1:0] b_s1,
	output logic                               valid_q,
	output logic signed [wto_pkg::SampleW-1:0] sample_q
);

	logic                               valid_s2;
	logic signed [wto_pkg::ProdW-1:0]   prod_a_s2;
	logic signed [wto_pkg::ProdW-1:0]   prod_b_s2;
	logic signed [wto_pkg::FracW:0]     w_a;
	logic signed [wto_pkg::FracW:0]     w_b;
	logic signed [wto_pkg::ProdW-1:0]   sum;

	// Both weights are non-negative, so a zero top bit makes them signed.
	assign w_a = $signed({1'b0, wto_pkg::WeightFull - ctl_s1.frac});
	assign w_b = $signed({1'b0, ctl_s1.frac});
	assign sum = prod_a_s2 + prod_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= ctl_s1.valid;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s2 <= wto_pkg::ProdW'(a_s1 * w_a);
			prod_b_s2 <= wto_pkg::ProdW'(b_s1 * w_b);
			sample_q  <= sum[2*wto_pkg::SampleW-1:wto_pkg::SampleW];
		end
	end

endmodule

/* rtl/core/wto_checker.sv */
// Port-level checks for the wavetable oscillator core, bound to the top level.
module wto_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               in_func,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [wto_pkg::SampleW-1:0] out_sample
);

	// A waiting sample is not withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// A waiting sample does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample))
		else $error("output sample changed while stalled");

	// The input side is never blocked unless a finished sample is stuck.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	// A tick item with a free-running output appears once through the pipeline.
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_func == wto_pkg::FuncTick)) ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("tick item did not produce a sample");

endmodule

bind wavetable_oscillator_interp_core wto_checker u_wto_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_func    (in_ch.func),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.sample)
);

/* verif/wavetable_oscillator_interp_core_test.sv */
// Self-checking testbench for the wavetable oscillator core with linear interpolation.
`timescale 1ns / 1ps

module wavetable_oscillator_interp_core_test;

	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 4;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [wto_pkg::PhaseW-1:0] cfg_data;

	wto_in_if  in_if();
	wto_out_if out_if();

	wavetable_oscillator_interp_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_if),
		.out_ch   (out_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Predictor state, updated as items are accepted.
	logic [wto_pkg::PhaseW-1:0]         phase_acc;
	logic [wto_pkg::PhaseW-1:0]         step_reg;
	logic signed [wto_pkg::SampleW-1:0] wave_mem [wto_pkg::TableDepth];
	bit                                 written [wto_pkg::TableDepth];
	logic signed [wto_pkg::SampleW-1:0] expected_samples [$];

	int  errors;
	int  quiet_cycles;
	bit  idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [wto_pkg::SampleW-1:0] interp_sample();
		logic [wto_pkg::AddrW-1:0] pos;
		logic [wto_pkg::AddrW-1:0] nxt;
		int                        frac;
		int                        sum;
		logic [15:0]               bits;
		pos  = phase_acc[31:24];
		nxt  = pos + 8'd1;
		frac = int'(phase_acc[23:16]);
		sum  = int'(wave_mem[pos]) * (int'(wto_pkg::WeightFull) - frac)
			+ int'(wave_mem[nxt]) * frac;
		bits = sum[15:0];
		return bits[15:8];
	endfunction

	task automatic send_item(input logic fn, input logic [wto_pkg::AddrW-1:0] addr,
		input logic signed [wto_pkg::SampleW-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid       <= 1'b1;
		in_if.func        <= fn;
		in_if.entry_addr  <= addr;
		in_if.entry_value <= val;
		do @(posedge clk); while (!in_if.ready);
		if (fn == wto_pkg::FuncWrite) begin
			wave_mem[addr] = val;
			written[addr]  = 1'b1;
		end else begin
			expected_samples.push_back(interp_sample());
			phase_acc = phase_acc + step_reg;
		end
	endtask

	// A tick may only read entries that hold a value, so missing ones are filled first.
	task automatic send_tick();
		logic [wto_pkg::AddrW-1:0] idx;
		idx = phase_acc[31:24];
		repeat (2) begin
			if (!written[idx])
				send_item(wto_pkg::FuncWrite, idx, 8'($urandom));
			idx = idx + 8'd1;
		end
		send_item(wto_pkg::FuncTick, 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_step(input logic [wto_pkg::PhaseW-1:0] v);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		step_reg = v;
	endtask

	task automatic test_directed_edges();
		idle_on = 1'b0;
		write_step(32'h0000_0000);
		send_item(wto_pkg::FuncWrite, 8'd0, 8'h7F);
		send_item(wto_pkg::FuncWrite, 8'd1, 8'h7F);
		send_tick();
		send_item(wto_pkg::FuncWrite, 8'd0, 8'h80);
		send_item(wto_pkg::FuncWrite, 8'd1, 8'h80);
		send_tick();
		write_step(32'hFFFF_0000);
		send_item(wto_pkg::FuncWrite, 8'd255, 8'h7F);
		send_tick();
		// The phase now sits on the last entry with full fraction, so entry 0 is the neighbor.
		send_tick();
		send_tick();
		write_step(32'hFFFF_FFFF);
		send_item(wto_pkg::FuncWrite, 8'd254, 8'h00);
		send_item(wto_pkg::FuncWrite, 8'd255, 8'hFF);
		repeat (3) send_tick();
		write_step(32'h0080_0000);
		repeat (3) send_tick();
	endtask

	task automatic run_traffic(input logic [wto_pkg::PhaseW-1:0] step, input int count,
		input bit with_idle);
		int n;
		idle_on = with_idle;
		write_step(step);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 3)
				send_item(wto_pkg::FuncWrite, 8'($urandom), 8'($urandom));
			else
				send_tick();
		end
	endtask

	task automatic test_slow_sweep();
		run_traffic(32'h0000_0001, 75, 1'b1);
	endtask

	task automatic test_entry_stride();
		run_traffic(32'h0100_0000, 75, 1'b1);
	endtask

	task automatic test_max_step();
		run_traffic(32'hFFFF_FFFF, 75, 1'b1);
	endtask

	task automatic test_random_steps();
		repeat (3) run_traffic($urandom, 75, 1'b1);
	endtask

	task automatic test_back_to_back();
		run_traffic($urandom, 80, 1'b0);
	endtask

	initial begin
		arst_n            = 1'b0;
		errors            = 0;
		idle_on           = 1'b0;
		phase_acc         = '0;
		step_reg          = '0;
		in_if.valid       <= 1'b0;
		in_if.func        <= wto_pkg::FuncTick;
		in_if.entry_addr  <= '0;
		in_if.entry_value <= '0;
		cfg_we            <= 1'b0;
		cfg_data          <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_slow_sweep();
		test_entry_stride();
		test_max_step();
		test_random_steps();
		test_back_to_back();

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls of the ready line while idling is enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_if.ready <= 1'b0;
				stall_left--;
			end else begin
				out_if.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		logic signed [wto_pkg::SampleW-1:0] want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample: no item expected, got %0d", out_if.sample);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (out_if.sample !== want) begin
					$error("sample: expected %0d, got %0d", want, out_if.sample);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
